[hw/rtl/sprite_sheet_frame_animator_top_macros.svh]
// Assertion helpers shared by the RTL; clk and arst_n are taken from the module using them.
`ifndef SPRITE_SHEET_FRAME_ANIMATOR_TOP_MACROS_SVH
`define SPRITE_SHEET_FRAME_ANIMATOR_TOP_MACROS_SVH

// Property must hold at every edge outside reset
`define SSFA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset
`define SSFA_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[hw/rtl/ssfa_pkg.sv]
package ssfa_pkg;

	// default fraction width of all Q values
	localparam int FRAC_BITS_DEF = 16;

	// wide signed type used ahead of 32-bit saturation
	localparam int SAT_W = 72;
	typedef logic signed [SAT_W-1:0] wide_t;

	// configuration register indexes
	localparam logic [2:0] REG_MODE  = 3'd0;
	localparam logic [2:0] REG_COLS  = 3'd1;
	localparam logic [2:0] REG_ROWS  = 3'd2;
	localparam logic [2:0] REG_SEQ   = 3'd3;
	localparam logic [2:0] REG_START = 3'd4;
	localparam logic [2:0] REG_RATE  = 3'd5;

	// mode bit positions
	localparam int MB_ON       = 0;
	localparam int MB_LOOP     = 1;
	localparam int MB_REVERSE  = 2;
	localparam int MB_PINGPONG = 3;
	localparam int MB_SMOOTH   = 4;
	localparam int MB_ROTATE   = 5;
	localparam int MB_SCALE    = 6;

	// datapath operations
	localparam logic [4:0] OP_NOP     = 5'd0;
	localparam logic [4:0] OP_LOAD    = 5'd1;
	localparam logic [4:0] OP_MUL     = 5'd2;
	localparam logic [4:0] OP_FC      = 5'd3;
	localparam logic [4:0] OP_CLAMP   = 5'd4;
	localparam logic [4:0] OP_DIV_FL  = 5'd5;
	localparam logic [4:0] OP_MOD_END = 5'd6;
	localparam logic [4:0] OP_POST1   = 5'd7;
	localparam logic [4:0] OP_POST2   = 5'd8;
	localparam logic [4:0] OP_POST3   = 5'd9;
	localparam logic [4:0] OP_UPD     = 5'd10;
	localparam logic [4:0] OP_DIV_SS  = 5'd11;
	localparam logic [4:0] OP_CAP_SS  = 5'd12;
	localparam logic [4:0] OP_DIV_ST  = 5'd13;
	localparam logic [4:0] OP_CAP_ST  = 5'd14;
	localparam logic [4:0] OP_DIV_CW  = 5'd15;
	localparam logic [4:0] OP_CAP_XY  = 5'd16;
	localparam logic [4:0] OP_MULX    = 5'd17;
	localparam logic [4:0] OP_MULY    = 5'd18;
	localparam logic [4:0] OP_GRID    = 5'd19;

	typedef struct packed {
		logic [4:0] op;
	} ssfa_cmd_t;

	typedef struct packed {
		logic restart;
		logic on;
		logic loop;
		logic changed;
		logic grid_upd;
		logic div_busy;
	} ssfa_stat_t;

	// clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat32(wide_t x);
		if (x > wide_t'(32'sh7FFF_FFFF)) begin
			return 32'sh7FFF_FFFF;
		end else if (x < wide_t'(32'sh8000_0000)) begin
			return 32'sh8000_0000;
		end
		return x[31:0];
	endfunction

endpackage

[hw/rtl/ssfa_div.sv]
module ssfa_div #(
	parameter int DW = 33
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic [DW-1:0] quot,
	output logic [DW-1:0] rem,
	output logic          busy
);

	localparam int CW = $clog2(DW + 1);

	logic [DW:0]   rem_q;
	logic [DW-1:0] quo_q;
	logic [DW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   shifted;
	logic [DW:0]   trial;

	// restoring step: one quotient bit per cycle
	assign shifted = {rem_q[DW-1:0], quo_q[DW-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(DW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!trial[DW]) begin
				rem_q <= trial;
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign quot = quo_q;
	assign rem  = rem_q[DW-1:0];
	assign busy = (cnt_q != '0);

endmodule

[hw/rtl/ssfa_datapath.sv]
module ssfa_datapath #(
	parameter int FRAC_BITS = ssfa_pkg::FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ssfa_pkg::ssfa_cmd_t    cmd,
	output ssfa_pkg::ssfa_stat_t   stat,
	input  logic                   command,
	input  logic [31:0]            elapsed,
	input  logic [6:0]             mode_bits,
	input  logic [7:0]             grid_columns,
	input  logic [7:0]             grid_rows,
	input  logic [31:0]            sequence_length,
	input  logic signed [31:0]     start_frame,
	input  logic signed [31:0]     frame_rate,
	output logic [2:0]             update_mask,
	output logic signed [31:0]     offset_s,
	output logic signed [31:0]     offset_t,
	output logic signed [31:0]     scale_s_out,
	output logic signed [31:0]     scale_t_out,
	output logic signed [31:0]     rotation
);

	// divider width covers |frame| and the doubled frame count
	localparam int DW = (FRAC_BITS + 17 > 33) ? FRAC_BITS + 17 : 33;
	localparam int W  = DW + 3;
	localparam int PW = W + FRAC_BITS + 2;

	localparam logic signed [W-1:0] Q_ONE  = W'(1) << FRAC_BITS;
	localparam logic signed [W-1:0] Q_HALF = Q_ONE >>> 1;
	localparam logic signed [W-1:0] Q_EPS  = (Q_ONE + 50) / 100;
	localparam logic signed [W-1:0] Q_199  = (199 * Q_ONE + 50) / 100;
	localparam logic signed [W-1:0] Q_099  = (99 * Q_ONE + 50) / 100;
	localparam logic signed [W-1:0] LOW_M  = Q_ONE - 1;

	logic smooth, loop_m, pp, rev, rot_m, scl_m, grid;
	assign smooth = mode_bits[ssfa_pkg::MB_SMOOTH];
	assign loop_m = mode_bits[ssfa_pkg::MB_LOOP];
	assign pp     = mode_bits[ssfa_pkg::MB_PINGPONG];
	assign rev    = mode_bits[ssfa_pkg::MB_REVERSE];
	assign rot_m  = mode_bits[ssfa_pkg::MB_ROTATE];
	assign scl_m  = mode_bits[ssfa_pkg::MB_SCALE];
	assign grid   = (grid_columns != 8'd0) && (grid_rows != 8'd0);

	// state
	logic [31:0]        timer_q;
	logic signed [31:0] last_time_q, last_frame_q;
	logic               lfv_q, restart_q;
	logic signed [31:0] held_os_q, held_ot_q, held_ss_q, held_st_q, held_rot_q;
	logic [2:0]         mask_q;

	// working registers
	logic signed [W-1:0]  nf_q, fl_q, fc_q, xf_q, yf_q;
	logic signed [64:0]   prod_q;
	logic [FRAC_BITS:0]   ss_q, st_q;
	logic signed [PW-1:0] xp_q, yp_q;

	// timer add and frame count
	logic [32:0]         tsum;
	logic [15:0]         cells;
	logic signed [W-1:0] nf_c, fl_c;

	assign tsum  = {1'b0, timer_q} + {1'b0, elapsed};
	assign cells = 16'(grid_columns) * 16'(grid_rows);

	always_comb begin
		if (sequence_length != 32'd0) begin
			nf_c = $signed(W'(sequence_length));
		end else begin
			nf_c = $signed(W'((cells == 16'd0) ? 16'd1 : cells)) <<< FRAC_BITS;
		end
		if (pp) begin
			if (smooth) begin
				fl_c = nf_c <<< 1;
			end else if (loop_m) begin
				fl_c = (nf_c <<< 1) - (Q_ONE <<< 1);
			end else begin
				fl_c = (nf_c <<< 1) - Q_ONE;
			end
			if (fl_c < Q_ONE) begin
				fl_c = Q_ONE;
			end
		end else begin
			fl_c = nf_c;
		end
	end

	// raw frame from timer product
	ssfa_pkg::wide_t    fcw;
	logic signed [31:0] fc_sat;
	assign fcw    = ssfa_pkg::wide_t'(prod_q >>> FRAC_BITS)
		+ (smooth ? ssfa_pkg::wide_t'(last_time_q) : ssfa_pkg::wide_t'(0));
	assign fc_sat = ssfa_pkg::sat32(fcw);

	// post steps: stepping, fold, reverse, offset, rounding
	logic signed [W-1:0] a1, a2, a3;
	logic signed [31:0]  a3_sat;

	always_comb begin
		a1 = smooth ? fc_q : ((fc_q + Q_EPS) & ~LOW_M);
		if (pp && (a1 >= nf_q)) begin
			a1 = (nf_q <<< 1) - (smooth ? W'(0) : Q_199) - a1;
		end
		a2 = rev ? (nf_q - (smooth ? W'(0) : Q_099) - fc_q) : fc_q;
		a2 = a2 + W'(start_frame);
		a3 = smooth ? fc_q : ((fc_q + Q_HALF) & ~LOW_M);
	end
	assign a3_sat = ssfa_pkg::sat32(ssfa_pkg::wide_t'(a3));

	// divider operands
	logic [DW-1:0]       div_a, div_b, div_q, div_r;
	logic                div_start, div_busy;
	logic signed [W-1:0] fc_abs, rem_w, quo_w;

	assign fc_abs = fc_q[W-1] ? -fc_q : fc_q;

	always_comb begin
		div_start = 1'b0;
		div_a     = fc_abs[DW-1:0];
		div_b     = fl_q[DW-1:0];
		case (cmd.op)
			ssfa_pkg::OP_DIV_FL: begin
				div_start = 1'b1;
			end
			ssfa_pkg::OP_DIV_SS: begin
				div_start = 1'b1;
				div_a     = DW'(Q_ONE) + DW'(grid_columns >> 1);
				div_b     = DW'(grid_columns);
			end
			ssfa_pkg::OP_DIV_ST: begin
				div_start = 1'b1;
				div_a     = DW'(Q_ONE) + DW'(grid_rows >> 1);
				div_b     = DW'(grid_rows);
			end
			ssfa_pkg::OP_DIV_CW: begin
				div_start = 1'b1;
				div_b     = DW'(grid_columns) << FRAC_BITS;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	ssfa_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.quot     (div_q),
		.rem      (div_r),
		.busy     (div_busy)
	);

	// truncating division: sign follows the frame
	always_comb begin
		rem_w = $signed(W'(div_r));
		quo_w = $signed(W'(div_q));
		if (fc_q[W-1]) begin
			rem_w = -rem_w;
			quo_w = -quo_w;
		end
	end

	// grid offsets
	logic signed [31:0] gos, got;
	assign gos = ssfa_pkg::sat32(ssfa_pkg::wide_t'(-Q_HALF)
		+ ssfa_pkg::wide_t'($signed({1'b0, ss_q >> 1}))
		+ ssfa_pkg::wide_t'(xp_q >>> FRAC_BITS));
	assign got = ssfa_pkg::sat32(ssfa_pkg::wide_t'(Q_HALF)
		- ssfa_pkg::wide_t'($signed({1'b0, st_q >> 1}))
		- ssfa_pkg::wide_t'(yp_q));

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q      <= '0;
			last_time_q  <= '0;
			last_frame_q <= '0;
			lfv_q        <= 1'b0;
			restart_q    <= 1'b0;
			held_os_q    <= '0;
			held_ot_q    <= '0;
			held_ss_q    <= 32'(Q_ONE);
			held_st_q    <= 32'(Q_ONE);
			held_rot_q   <= '0;
			mask_q       <= '0;
		end else begin
			case (cmd.op)
				ssfa_pkg::OP_LOAD: begin
					restart_q <= command;
					mask_q    <= '0;
					if (command) begin
						timer_q <= '0;
					end else begin
						timer_q <= tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
						if (!mode_bits[ssfa_pkg::MB_ON]) begin
							last_time_q <= '0;
							lfv_q       <= 1'b0;
						end
					end
				end
				ssfa_pkg::OP_FC: begin
					last_time_q <= fc_sat;
					if (smooth) begin
						timer_q <= '0;
					end
				end
				ssfa_pkg::OP_UPD: begin
					last_frame_q <= fc_q[31:0];
					lfv_q        <= 1'b1;
					if (rot_m) begin
						mask_q     <= 3'd4;
						held_rot_q <= fc_q[31:0];
					end else if (scl_m) begin
						mask_q    <= 3'd2;
						held_ss_q <= fc_q[31:0];
						held_st_q <= fc_q[31:0];
					end else if (grid) begin
						mask_q <= 3'd3;
					end else begin
						mask_q    <= 3'd1;
						held_ss_q <= 32'(Q_ONE);
						held_st_q <= 32'(Q_ONE);
						held_os_q <= fc_q[31:0];
						held_ot_q <= '0;
					end
				end
				ssfa_pkg::OP_GRID: begin
					held_ss_q <= 32'(ss_q);
					held_st_q <= 32'(st_q);
					held_os_q <= gos;
					held_ot_q <= got;
				end
				default: begin
					mask_q <= mask_q;
				end
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			ssfa_pkg::OP_LOAD: begin
				nf_q <= nf_c;
				fl_q <= fl_c;
			end
			ssfa_pkg::OP_MUL:     prod_q <= $signed({1'b0, timer_q}) * frame_rate;
			ssfa_pkg::OP_FC:      fc_q   <= W'(fc_sat);
			ssfa_pkg::OP_CLAMP: begin
				if (fc_q > fl_q - Q_ONE) begin
					fc_q <= fl_q - Q_ONE;
				end
			end
			ssfa_pkg::OP_MOD_END: fc_q   <= rem_w;
			ssfa_pkg::OP_POST1:   fc_q   <= a1;
			ssfa_pkg::OP_POST2:   fc_q   <= a2;
			ssfa_pkg::OP_POST3:   fc_q   <= W'(a3_sat);
			ssfa_pkg::OP_CAP_SS:  ss_q   <= div_q[FRAC_BITS:0];
			ssfa_pkg::OP_CAP_ST:  st_q   <= div_q[FRAC_BITS:0];
			ssfa_pkg::OP_CAP_XY: begin
				xf_q <= rem_w;
				yf_q <= quo_w;
			end
			ssfa_pkg::OP_MULX:    xp_q   <= xf_q * $signed({1'b0, ss_q});
			ssfa_pkg::OP_MULY:    yp_q   <= yf_q * $signed({1'b0, st_q});
			default: begin
				fc_q <= fc_q;
			end
		endcase
	end

	assign stat.restart  = restart_q;
	assign stat.on       = mode_bits[ssfa_pkg::MB_ON];
	assign stat.loop     = loop_m;
	assign stat.changed  = !lfv_q || (last_frame_q != fc_q[31:0]);
	assign stat.grid_upd = !rot_m && !scl_m && grid;
	assign stat.div_busy = div_busy;

	assign update_mask = mask_q;
	assign offset_s    = held_os_q;
	assign offset_t    = held_ot_q;
	assign scale_s_out = held_ss_q;
	assign scale_t_out = held_st_q;
	assign rotation    = held_rot_q;

endmodule

[hw/rtl/ssfa_ctrl.sv]
`include "sprite_sheet_frame_animator_top_macros.svh"

module ssfa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 out_free,
	output logic                 emit,
	output ssfa_pkg::ssfa_cmd_t  cmd,
	input  ssfa_pkg::ssfa_stat_t stat
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_CHECK  = 5'd1;
	localparam logic [4:0] S_MUL    = 5'd2;
	localparam logic [4:0] S_FC     = 5'd3;
	localparam logic [4:0] S_CLAMP  = 5'd4;
	localparam logic [4:0] S_MODGO  = 5'd5;
	localparam logic [4:0] S_MODW   = 5'd6;
	localparam logic [4:0] S_POST1  = 5'd7;
	localparam logic [4:0] S_POST2  = 5'd8;
	localparam logic [4:0] S_POST3  = 5'd9;
	localparam logic [4:0] S_DECIDE = 5'd10;
	localparam logic [4:0] S_SSGO   = 5'd11;
	localparam logic [4:0] S_SSW    = 5'd12;
	localparam logic [4:0] S_STGO   = 5'd13;
	localparam logic [4:0] S_STW    = 5'd14;
	localparam logic [4:0] S_CWGO   = 5'd15;
	localparam logic [4:0] S_CWW    = 5'd16;
	localparam logic [4:0] S_MULX   = 5'd17;
	localparam logic [4:0] S_MULY   = 5'd18;
	localparam logic [4:0] S_GRID   = 5'd19;
	localparam logic [4:0] S_DONE   = 5'd20;

	logic [4:0] state_q, state_d;
	logic       div_go;

	always_comb begin
		state_d  = state_q;
		cmd.op   = ssfa_pkg::OP_NOP;
		emit     = 1'b0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = ssfa_pkg::OP_LOAD;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = (stat.restart || !stat.on) ? S_DONE : S_MUL;
			end
			S_MUL: begin
				cmd.op  = ssfa_pkg::OP_MUL;
				state_d = S_FC;
			end
			S_FC: begin
				cmd.op  = ssfa_pkg::OP_FC;
				state_d = stat.loop ? S_MODGO : S_CLAMP;
			end
			S_CLAMP: begin
				cmd.op  = ssfa_pkg::OP_CLAMP;
				state_d = S_POST1;
			end
			S_MODGO: begin
				cmd.op  = ssfa_pkg::OP_DIV_FL;
				state_d = S_MODW;
			end
			S_MODW: begin
				if (!stat.div_busy) begin
					cmd.op  = ssfa_pkg::OP_MOD_END;
					state_d = S_POST1;
				end
			end
			S_POST1: begin
				cmd.op  = ssfa_pkg::OP_POST1;
				state_d = S_POST2;
			end
			S_POST2: begin
				cmd.op  = ssfa_pkg::OP_POST2;
				state_d = S_POST3;
			end
			S_POST3: begin
				cmd.op  = ssfa_pkg::OP_POST3;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (stat.changed) begin
					cmd.op  = ssfa_pkg::OP_UPD;
					state_d = stat.grid_upd ? S_SSGO : S_DONE;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SSGO: begin
				cmd.op  = ssfa_pkg::OP_DIV_SS;
				state_d = S_SSW;
			end
			S_SSW: begin
				if (!stat.div_busy) begin
					cmd.op  = ssfa_pkg::OP_CAP_SS;
					state_d = S_STGO;
				end
			end
			S_STGO: begin
				cmd.op  = ssfa_pkg::OP_DIV_ST;
				state_d = S_STW;
			end
			S_STW: begin
				if (!stat.div_busy) begin
					cmd.op  = ssfa_pkg::OP_CAP_ST;
					state_d = S_CWGO;
				end
			end
			S_CWGO: begin
				cmd.op  = ssfa_pkg::OP_DIV_CW;
				state_d = S_CWW;
			end
			S_CWW: begin
				if (!stat.div_busy) begin
					cmd.op  = ssfa_pkg::OP_CAP_XY;
					state_d = S_MULX;
				end
			end
			S_MULX: begin
				cmd.op  = ssfa_pkg::OP_MULX;
				state_d = S_MULY;
			end
			S_MULY: begin
				cmd.op  = ssfa_pkg::OP_MULY;
				state_d = S_GRID;
			end
			S_GRID: begin
				cmd.op  = ssfa_pkg::OP_GRID;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// any command that launches the divider
	assign div_go = (cmd.op == ssfa_pkg::OP_DIV_FL) || (cmd.op == ssfa_pkg::OP_DIV_SS)
		|| (cmd.op == ssfa_pkg::OP_DIV_ST) || (cmd.op == ssfa_pkg::OP_DIV_CW);

	// a divide is launched only onto an idle divider
	`SSFA_NEVER(a_div_start_busy, div_go && stat.div_busy, "divide started while divider busy")
	// a result is handed over only into a free output slot
	`SSFA_NEVER(a_emit_full, emit && !out_free, "result emitted into full output register")
	// after a result the controller is ready for the next beat
	`SSFA_ASSERT(a_emit_ready, emit |=> in_ready, "not ready after result")

endmodule

[hw/rtl/sprite_sheet_frame_animator_top.sv]
// Channel   | Signals                               | Payload (lowest bit first)
// s_axis    | s_axis_tvalid/tready/tdata/tuser      | tdata: elapsed; tuser: command
// m_axis    | m_axis_tvalid/tready/tdata/tuser      | tdata: offset_s, offset_t,
//           |                                       |   scale_s_out, scale_t_out, rotation;
//           |                                       |   tuser: update_mask
// cfg       | cfg_valid/cfg_ready/cfg_index/cfg_data| register index 0..5, 32-bit data
//
// One item at a time; the next beat is taken while a result waits in m_axis.
// Restart or disabled ticks go straight to the emit; other ticks multiply, form the frame,
// then clamp it or, when looping, take one divider pass (DW = max(FRAC_BITS+17, 33)),
// and run the post steps; a grid update adds three divider passes, two multiplies and
// the grid step. All divides share one 1-bit/cycle divider; the emit waits while m_axis
// holds an untaken result. Reset clears all state but working registers and output data.
module sprite_sheet_frame_animator_top #(
	parameter int FRAC_BITS = ssfa_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [31:0]  s_axis_tdata,  // [31:0] elapsed
	input  logic [0:0]   s_axis_tuser,  // [0] command
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [159:0] m_axis_tdata,  // offset_s, offset_t, scale_s_out, scale_t_out, rotation
	output logic [2:0]   m_axis_tuser,  // [2:0] update_mask
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	// configuration registers
	logic [6:0]         mode_q;
	logic [7:0]         cols_q, rows_q;
	logic [31:0]        seq_q;
	logic signed [31:0] start_q, rate_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= '0;
			cols_q  <= '0;
			rows_q  <= '0;
			seq_q   <= '0;
			start_q <= '0;
			rate_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				ssfa_pkg::REG_MODE:  mode_q  <= cfg_data[6:0];
				ssfa_pkg::REG_COLS:  cols_q  <= cfg_data[7:0];
				ssfa_pkg::REG_ROWS:  rows_q  <= cfg_data[7:0];
				ssfa_pkg::REG_SEQ:   seq_q   <= cfg_data;
				ssfa_pkg::REG_START: start_q <= cfg_data;
				ssfa_pkg::REG_RATE:  rate_q  <= cfg_data;
				default: begin
					mode_q <= mode_q;
				end
			endcase
		end
	end

	ssfa_pkg::ssfa_cmd_t  cmd;
	ssfa_pkg::ssfa_stat_t stat;
	logic               out_free, emit;
	logic [2:0]         mask;
	logic signed [31:0] os, ot, ss, st, rot;

	assign out_free = !m_axis_tvalid || m_axis_tready;

	ssfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_free (out_free),
		.emit     (emit),
		.cmd      (cmd),
		.stat     (stat)
	);

	ssfa_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.command         (s_axis_tuser[0]),
		.elapsed         (s_axis_tdata),
		.mode_bits       (mode_q),
		.grid_columns    (cols_q),
		.grid_rows       (rows_q),
		.sequence_length (seq_q),
		.start_frame     (start_q),
		.frame_rate      (rate_q),
		.update_mask     (mask),
		.offset_s        (os),
		.offset_t        (ot),
		.scale_s_out     (ss),
		.scale_t_out     (st),
		.rotation        (rot)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (emit) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_axis_tdata <= {rot, st, ss, ot, os};
			m_axis_tuser <= mask;
		end
	end

endmodule
